FILE: rtl/path_token_canonicalizer_assert.svh
// assertion macros for the path token canonicaliser
// depends on nothing; included by the top level only
`ifndef PATH_TOKEN_CANONICALIZER_ASSERT_SVH
`define PATH_TOKEN_CANONICALIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define PTC_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PTC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PTC_ASSERT_SAME(name, clk, rst_n, ante, cons, msg)
`define PTC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/ptc_pkg.sv
// shared types, constants and character classes for the path token canonicaliser
// depends on nothing
package ptc_pkg;

  localparam int MaxRun  = 63;
  localparam int OutMax  = 4096;
  localparam int RunAw   = $clog2(MaxRun);
  localparam int RunLenW = $clog2(MaxRun + 2);
  localparam int CntW    = $clog2(OutMax);
  localparam int CapW    = 13;

  localparam logic [7:0] HashChar  = 8'h23;
  localparam logic [7:0] SlashChar = 8'h2F;
  localparam logic [CapW-1:0] CapReset = CapW'(OutMax);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_HASH   = 7'b0000100,
    S_FETCH  = 7'b0001000,
    S_EMIT   = 7'b0010000,
    S_PASS   = 7'b0100000,
    S_END    = 7'b1000000
  } state_e;

  typedef enum logic [1:0] {
    SEL_BUF,
    SEL_HASH,
    SEL_PASS,
    SEL_BARE
  } emit_sel_e;

  typedef struct packed {
    logic      accept;
    logic      emit;
    emit_sel_e sel;
    logic      last_cand;
    logic      idx_inc;
    logic      finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_word;
    logic run_empty;
    logic gen;
    logic has_more;
    logic word;
    logic fin;
    logic any_emitted;
    logic out_free;
  } dp_status_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return c inside {[8'h41:8'h5A]};
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return c inside {[8'h61:8'h7A]};
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_digit(c) | is_upper(c) | is_lower(c);
  endfunction

endpackage

FILE: rtl/ptc_ram.sv
// generic single-write, single-read memory with registered read data
// depends on nothing
module ptc_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/ptc_datapath.sv
// run buffer, run classification, output counting and the result register
// depends on ptc_pkg and ptc_ram
module ptc_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [ptc_pkg::CapW-1:0] cfg_wdata_i,
  input  logic [7:0]              path_byte_i,
  input  logic                    final_byte_i,
  input  logic                    out_ready_i,
  input  ptc_pkg::ctrl_cmd_t      cmd_i,
  output ptc_pkg::dp_status_t     status_o,
  output logic                    out_valid_o,
  output logic [7:0]              out_byte_o,
  output logic                    byte_valid_o,
  output logic                    end_of_path_o,
  output logic [ptc_pkg::CntW-1:0] out_length_o,
  output logic                    run_truncated_o,
  output logic                    last_result_o
);

  logic [ptc_pkg::CapW-1:0]    cap_q;
  logic [ptc_pkg::RunLenW-1:0] run_len_q, run_len_d;
  logic all_hex_q, all_hex_d, all_dec_q, all_dec_d;
  logic seen_up_q, seen_up_d, seen_lo_q, seen_lo_d, seen_dig_q, seen_dig_d;
  logic seg_start_q, seg_start_d, began_q, began_d;
  logic [ptc_pkg::CntW-1:0]    count_q, count_d;
  logic [ptc_pkg::RunAw-1:0]   idx_q, idx_d;
  logic any_q, any_d;
  logic out_valid_q, out_valid_d;

  logic [7:0] cur_byte_q;
  logic       fin_q, word_q, seg_end_q;

  logic [7:0]               out_byte_q;
  logic                     bv_q, eop_q, trunc_q, last_q;
  logic [ptc_pkg::CntW-1:0] len_q;

  logic                        in_word, ram_we, run_trunc, can_emit, full_after, load;
  logic [7:0]                  rdata, cand_byte;
  logic                        cand_trunc, gen;
  logic [ptc_pkg::RunLenW-1:0] keep;
  logic [ptc_pkg::CapW-1:0]    limit, next_cnt;
  logic [ptc_pkg::CapW:0]      cnt_plus2;

  assign in_word   = ptc_pkg::is_word(path_byte_i);
  assign run_trunc = run_len_q > ptc_pkg::RunLenW'(ptc_pkg::MaxRun);
  assign keep      = run_trunc ? ptc_pkg::RunLenW'(ptc_pkg::MaxRun) : run_len_q;
  assign ram_we    = cmd_i.accept & in_word & (run_len_q < ptc_pkg::RunLenW'(ptc_pkg::MaxRun));

  ptc_ram #(
    .Width (8),
    .Depth (ptc_pkg::MaxRun)
  ) u_run_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (run_len_q[ptc_pkg::RunAw-1:0]),
    .wdata_i (path_byte_i),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  assign gen = (began_q & seg_end_q & all_dec_q) |
               ((run_len_q >= ptc_pkg::RunLenW'(8)) & all_hex_q) |
               ((run_len_q >= ptc_pkg::RunLenW'(16)) & seen_up_q & seen_lo_q & seen_dig_q);

  assign limit     = (cap_q > ptc_pkg::CapReset) ? ptc_pkg::CapReset : cap_q;
  assign next_cnt  = ptc_pkg::CapW'(count_q) + ptc_pkg::CapW'(1);
  assign cnt_plus2 = (ptc_pkg::CapW + 1)'(count_q) + (ptc_pkg::CapW + 1)'(2);
  assign can_emit  = next_cnt < limit;
  assign full_after = cnt_plus2 >= {1'b0, limit};

  always_comb begin
    case (cmd_i.sel)
      ptc_pkg::SEL_BUF: begin
        cand_byte  = rdata;
        cand_trunc = run_trunc;
      end
      ptc_pkg::SEL_HASH: begin
        cand_byte  = ptc_pkg::HashChar;
        cand_trunc = 1'b0;
      end
      default: begin
        cand_byte  = cur_byte_q;
        cand_trunc = 1'b0;
      end
    endcase
  end

  assign load = cmd_i.emit & ((cmd_i.sel == ptc_pkg::SEL_BARE) | can_emit);

  always_comb begin
    run_len_d   = run_len_q;
    all_hex_d   = all_hex_q;
    all_dec_d   = all_dec_q;
    seen_up_d   = seen_up_q;
    seen_lo_d   = seen_lo_q;
    seen_dig_d  = seen_dig_q;
    seg_start_d = seg_start_q;
    began_d     = began_q;
    count_d     = count_q;
    idx_d       = idx_q;
    any_d       = any_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (cmd_i.accept) begin
      idx_d = '0;
      any_d = 1'b0;
      if (in_word) begin
        if (run_len_q == '0) begin
          began_d = seg_start_q;
        end
        seg_start_d = 1'b0;
        if (run_len_q <= ptc_pkg::RunLenW'(ptc_pkg::MaxRun)) begin
          run_len_d = run_len_q + ptc_pkg::RunLenW'(1);
        end
        if (!ptc_pkg::is_hex(path_byte_i)) begin
          all_hex_d = 1'b0;
        end
        if (ptc_pkg::is_digit(path_byte_i)) begin
          seen_dig_d = 1'b1;
        end else begin
          all_dec_d = 1'b0;
          if (ptc_pkg::is_upper(path_byte_i)) begin
            seen_up_d = 1'b1;
          end else begin
            seen_lo_d = 1'b1;
          end
        end
      end
    end
    if (cmd_i.idx_inc) begin
      idx_d = idx_q + ptc_pkg::RunAw'(1);
    end
    if (load) begin
      out_valid_d = 1'b1;
      if (cmd_i.sel != ptc_pkg::SEL_BARE) begin
        count_d = next_cnt[ptc_pkg::CntW-1:0];
        any_d   = 1'b1;
      end
    end
    if (cmd_i.finish) begin
      run_len_d   = '0;
      all_hex_d   = 1'b1;
      all_dec_d   = 1'b1;
      seen_up_d   = 1'b0;
      seen_lo_d   = 1'b0;
      seen_dig_d  = 1'b0;
      began_d     = 1'b0;
      seg_start_d = fin_q | (cur_byte_q == ptc_pkg::SlashChar);
      if (fin_q) begin
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= ptc_pkg::CapReset;
      run_len_q   <= '0;
      all_hex_q   <= 1'b1;
      all_dec_q   <= 1'b1;
      seen_up_q   <= 1'b0;
      seen_lo_q   <= 1'b0;
      seen_dig_q  <= 1'b0;
      seg_start_q <= 1'b1;
      began_q     <= 1'b0;
      count_q     <= '0;
      idx_q       <= '0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      run_len_q   <= run_len_d;
      all_hex_q   <= all_hex_d;
      all_dec_q   <= all_dec_d;
      seen_up_q   <= seen_up_d;
      seen_lo_q   <= seen_lo_d;
      seen_dig_q  <= seen_dig_d;
      seg_start_q <= seg_start_d;
      began_q     <= began_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      any_q       <= any_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_byte_q <= path_byte_i;
      fin_q      <= final_byte_i;
      word_q     <= in_word;
      seg_end_q  <= in_word | (path_byte_i == ptc_pkg::SlashChar);
    end
    if (load) begin
      if (cmd_i.sel == ptc_pkg::SEL_BARE) begin
        out_byte_q <= 8'h00;
        bv_q       <= 1'b0;
        eop_q      <= 1'b1;
        len_q      <= count_q;
        trunc_q    <= 1'b0;
        last_q     <= 1'b1;
      end else begin
        out_byte_q <= cand_byte;
        bv_q       <= 1'b1;
        eop_q      <= fin_q & (cmd_i.last_cand | full_after);
        len_q      <= next_cnt[ptc_pkg::CntW-1:0];
        trunc_q    <= cand_trunc;
        last_q     <= cmd_i.last_cand | full_after;
      end
    end
  end

  assign status_o.in_word     = in_word;
  assign status_o.run_empty   = (run_len_q == '0);
  assign status_o.gen         = gen;
  assign status_o.has_more    = (ptc_pkg::RunLenW'(idx_q) + ptc_pkg::RunLenW'(1)) < keep;
  assign status_o.word        = word_q;
  assign status_o.fin         = fin_q;
  assign status_o.any_emitted = any_q;
  assign status_o.out_free    = ~out_valid_q | out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign byte_valid_o    = bv_q;
  assign end_of_path_o   = eop_q;
  assign out_length_o    = len_q;
  assign run_truncated_o = trunc_q;
  assign last_result_o   = last_q;

endmodule

FILE: rtl/ptc_ctrl.sv
// controller: sequences run flush, pass-through byte and end marker per item
// depends on ptc_pkg
module ptc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                final_byte_i,
  output logic                in_ready_o,
  input  ptc_pkg::dp_status_t status_i,
  output ptc_pkg::ctrl_cmd_t  cmd_o
);

  ptc_pkg::state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.sel     = ptc_pkg::SEL_PASS;
    case (state_q)
      ptc_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && (!status_i.in_word || final_byte_i)) begin
          state_d = ptc_pkg::S_DECIDE;
        end
      end
      ptc_pkg::S_DECIDE: begin
        if (status_i.run_empty) begin
          state_d = ptc_pkg::S_PASS;
        end else if (status_i.gen) begin
          state_d = ptc_pkg::S_HASH;
        end else begin
          state_d = ptc_pkg::S_FETCH;
        end
      end
      ptc_pkg::S_HASH: begin
        cmd_o.sel       = ptc_pkg::SEL_HASH;
        cmd_o.last_cand = status_i.word;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = status_i.word ? ptc_pkg::S_END : ptc_pkg::S_PASS;
        end
      end
      ptc_pkg::S_FETCH: begin
        state_d = ptc_pkg::S_EMIT;
      end
      ptc_pkg::S_EMIT: begin
        cmd_o.sel       = ptc_pkg::SEL_BUF;
        cmd_o.last_cand = status_i.word & ~status_i.has_more;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.has_more) begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ptc_pkg::S_FETCH;
          end else begin
            state_d = status_i.word ? ptc_pkg::S_END : ptc_pkg::S_PASS;
          end
        end
      end
      ptc_pkg::S_PASS: begin
        cmd_o.sel       = ptc_pkg::SEL_PASS;
        cmd_o.last_cand = 1'b1;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ptc_pkg::S_END;
        end
      end
      ptc_pkg::S_END: begin
        cmd_o.sel = ptc_pkg::SEL_BARE;
        if (status_i.fin && !status_i.any_emitted) begin
          if (status_i.out_free) begin
            cmd_o.emit   = 1'b1;
            cmd_o.finish = 1'b1;
            state_d      = ptc_pkg::S_IDLE;
          end
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = ptc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ptc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/path_token_canonicalizer.sv
// path token canonicaliser top level: a non-final alphanumeric item is accepted into the run;
// any other item then steps through DECIDE, HASH for a '#' run or FETCH and EMIT per
// copied run byte, PASS for a pass-through byte, then END; FETCH covers the run buffer's
// registered read port, and each emit waits for a free output. one item in flight at a time.
// async active-low reset: empty run, capacity 4096, no result pending;
// run buffer contents undefined and never read before being written
`include "path_token_canonicalizer_assert.svh"

module path_token_canonicalizer (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [ptc_pkg::CapW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               path_byte_i,
  input  logic                     final_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [7:0]               out_byte_o,
  output logic                     byte_valid_o,
  output logic                     end_of_path_o,
  output logic [ptc_pkg::CntW-1:0] out_length_o,
  output logic                     run_truncated_o,
  output logic                     last_result_o
);

  ptc_pkg::ctrl_cmd_t  cmd;
  ptc_pkg::dp_status_t status;

  ptc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .final_byte_i (final_byte_i),
    .in_ready_o   (in_ready_o),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  ptc_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .path_byte_i     (path_byte_i),
    .final_byte_i    (final_byte_i),
    .out_ready_i     (out_ready_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .end_of_path_o   (end_of_path_o),
    .out_length_o    (out_length_o),
    .run_truncated_o (run_truncated_o),
    .last_result_o   (last_result_o)
  );

  `PTC_ASSERT_SAME(a_eop_is_last, clk_i, rst_ni, out_valid_o && end_of_path_o, last_result_o, "end of path without last result")
  `PTC_ASSERT_SAME(a_bare_only_at_end, clk_i, rst_ni, out_valid_o && !byte_valid_o, end_of_path_o && !run_truncated_o, "bare marker not at end of path")
  `PTC_ASSERT_SAME(a_len_nonzero, clk_i, rst_ni, out_valid_o && byte_valid_o, out_length_o != '0, "emitted byte with zero length")
  `PTC_ASSERT_NEXT(a_busy_after_flush, clk_i, rst_ni, in_valid_i && in_ready_o && final_byte_i, !in_ready_o, "final item did not hold off input")

endmodule
